>>> rtl/core/assert_macros.svh
// Assertion macros for the deframer core.
// Clock and reset names are those of the top level: clock, reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LPPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define LPPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/lppd_pkg.sv
// Package of the length-prefixed packet deframer: widths, codes and types.
// No dependencies; used by the interfaces and every module of the core.
package lppd_pkg;

   localparam int BYTE_W          = 8;
   localparam int MSG_LEN_W       = 31;
   localparam int STATUS_W        = 2;
   localparam int HDR_BYTES       = 4;
   localparam int HDR_IDX_W       = 2;

   localparam logic [HDR_IDX_W-1:0] HDR_SEQ_IDX = HDR_IDX_W'(HDR_BYTES - 1);
   localparam logic [MSG_LEN_W-1:0] MAX_SIZE_RESET = MSG_LEN_W'(67108864);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DISCARD = 2'd2
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_OUT_OF_ORDER = 2'd1,
      ST_TOO_LARGE    = 2'd2
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              resync;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    payload_byte;
      logic                 byte_valid;
      logic                 end_of_message;
      logic [MSG_LEN_W-1:0] message_length;
      status_type           status;
   } result_type;

   typedef struct packed {
      logic advance;
      logic stage_full;
   } pipe_ctl_type;

endpackage

>>> rtl/core/lppd_if.sv
// Valid/ready channel interfaces for the deframer: received bytes and results.
// Depends on lppd_pkg for field widths.
interface lppd_req_if;
   logic                         valid;
   logic                         ready;
   logic [lppd_pkg::BYTE_W-1:0]  data_byte;
   logic                         resync;

   modport source (output valid, data_byte, resync, input ready);
   modport sink   (input valid, data_byte, resync, output ready);
endinterface

interface lppd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lppd_pkg::BYTE_W-1:0]    payload_byte;
   logic                           byte_valid;
   logic                           end_of_message;
   logic [lppd_pkg::MSG_LEN_W-1:0] message_length;
   logic [lppd_pkg::STATUS_W-1:0]  status;

   modport source (output valid, payload_byte, byte_valid, end_of_message,
                   message_length, status, input ready);
   modport sink   (input valid, payload_byte, byte_valid, end_of_message,
                   message_length, status, output ready);
endinterface

>>> rtl/core/lppd_in_stage.sv
// Input register of the deframer: holds one received transfer.
// Depends on lppd_pkg.
module lppd_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  lppd_pkg::item_type     in_item,
   output logic                   in_ready,
   input  logic                   advance,
   output lppd_pkg::pipe_ctl_type ctl,
   output lppd_pkg::item_type     item
);
   import lppd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            item_in = in_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign ctl.advance    = advance;
   assign ctl.stage_full = valid_ff;
   assign item           = item_ff;

endmodule

>>> rtl/core/lppd_parser.sv
// Header and payload parser of the deframer: chunk state, sequence check, size check.
// Depends on lppd_pkg.
module lppd_parser #(
   parameter int CHUNK_LENGTH_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [lppd_pkg::MSG_LEN_W-1:0]  max_size,
   input  lppd_pkg::pipe_ctl_type          ctl,
   input  lppd_pkg::item_type              item,
   output logic                            res_valid,
   output lppd_pkg::result_type            res
);
   import lppd_pkg::*;

   localparam int CLB = CHUNK_LENGTH_BITS;

   phase_type              phase_ff, phase_in;
   logic [HDR_IDX_W-1:0]   hdr_idx_ff, hdr_idx_in;
   logic [CLB-1:0]         chunk_ff, chunk_in;
   logic [CLB-1:0]         left_ff, left_in;
   logic [BYTE_W-1:0]      seq_ff, seq_in;
   logic [MSG_LEN_W-1:0]   msg_ff, msg_in;
   logic                   halted_ff, halted_in;

   logic                   step;
   logic [3*BYTE_W-1:0]    len_wide;
   logic [MSG_LEN_W:0]     total;
   logic [MSG_LEN_W-1:0]   total_sat;
   logic [MSG_LEN_W-1:0]   msg_inc;
   logic                   last_byte;

   assign step      = ctl.stage_full && ctl.advance;
   assign total     = {1'b0, msg_ff} + (MSG_LEN_W + 1)'(chunk_ff);
   assign total_sat = total[MSG_LEN_W] ? '1 : total[MSG_LEN_W-1:0];
   assign msg_inc   = msg_ff + MSG_LEN_W'(1);
   assign last_byte = (left_ff == CLB'(1));

   always_comb begin
      case (hdr_idx_ff)
         2'd0:    len_wide = {16'b0, item.data_byte};
         2'd1:    len_wide = {8'b0, item.data_byte, 8'b0};
         default: len_wide = {item.data_byte, 16'b0};
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      chunk_in   = chunk_ff;
      left_in    = left_ff;
      seq_in     = seq_ff;
      msg_in     = msg_ff;
      halted_in  = halted_ff;
      res_valid  = 1'b0;
      res        = '{payload_byte: '0, byte_valid: 1'b0, end_of_message: 1'b0,
                     message_length: '0, status: ST_OK};

      if (step) begin
         if (item.resync) begin
            phase_in   = PH_HEADER;
            hdr_idx_in = '0;
            chunk_in   = '0;
            left_in    = '0;
            seq_in     = '0;
            msg_in     = '0;
            halted_in  = 1'b0;
         end else if (!halted_ff) begin
            case (phase_ff)
               PH_PAYLOAD: begin
                  msg_in           = msg_inc;
                  left_in          = left_ff - CLB'(1);
                  res_valid        = 1'b1;
                  res.payload_byte = item.data_byte;
                  res.byte_valid   = 1'b1;
                  if (last_byte) begin
                     phase_in = PH_HEADER;
                     if (chunk_ff != '1) begin
                        res.end_of_message = 1'b1;
                        res.message_length = msg_inc;
                        msg_in             = '0;
                     end
                  end
               end
               PH_DISCARD: begin
                  left_in = left_ff - CLB'(1);
                  if (last_byte) begin
                     phase_in  = PH_HEADER;
                     halted_in = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_HEADER;
                  if (hdr_idx_ff != HDR_SEQ_IDX) begin
                     chunk_in   = ((hdr_idx_ff == '0) ? '0 : chunk_ff) | len_wide[CLB-1:0];
                     hdr_idx_in = hdr_idx_ff + HDR_IDX_W'(1);
                  end else begin
                     hdr_idx_in = '0;
                     res.end_of_message = 1'b1;
                     if (item.data_byte != seq_ff) begin
                        res_valid          = 1'b1;
                        res.message_length = msg_ff;
                        res.status         = ST_OUT_OF_ORDER;
                        halted_in          = 1'b1;
                     end else begin
                        seq_in = seq_ff + BYTE_W'(1);
                        if (chunk_ff == '0) begin
                           res_valid          = 1'b1;
                           res.message_length = msg_ff;
                           msg_in             = '0;
                        end else if (total >= {1'b0, max_size}) begin
                           res_valid          = 1'b1;
                           res.message_length = total_sat;
                           res.status         = ST_TOO_LARGE;
                           msg_in             = '0;
                           left_in            = chunk_ff;
                           phase_in           = PH_DISCARD;
                        end else begin
                           left_in  = chunk_ff;
                           phase_in = PH_PAYLOAD;
                        end
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_idx_ff <= '0;
         chunk_ff   <= '0;
         left_ff    <= '0;
         seq_ff     <= '0;
         msg_ff     <= '0;
         halted_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         chunk_ff   <= chunk_in;
         left_ff    <= left_in;
         seq_ff     <= seq_in;
         msg_ff     <= msg_in;
         halted_ff  <= halted_in;
      end
   end

endmodule

>>> rtl/core/lppd_out_stage.sv
// Result register of the deframer: holds one result until its transfer completes.
// Depends on lppd_pkg.
module lppd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  lppd_pkg::result_type res,
   output logic                 advance,
   output logic                 out_valid,
   output lppd_pkg::result_type out_res,
   input  logic                 out_ready
);
   import lppd_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign advance = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (advance) begin
         valid_in = res_valid;
         if (res_valid) begin
            res_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;

endmodule

>>> rtl/core/length_prefixed_packet_deframer_unit.sv
// Top level of the length-prefixed packet deframer core.
// Depends on lppd_pkg, lppd_if, lppd_in_stage, lppd_parser, lppd_out_stage, assert_macros.svh.
//
// Takes one received byte per cycle on req_ch, unless rsp_ch stalls, and splits the
// stream into chunks of a 3-byte little-endian length and a sequence byte followed
// by the payload; payload bytes come out on rsp_ch, a message's end (its last byte
// or an empty chunk's result) carrying the total length, and sequence or size errors
// come out as one flagged result after which the core drops bytes until a resync
// transfer. A byte that gives a result passes the input register, then the result
// register. req_ch.ready drops only while both registers are full and rsp_ch stalls.
// Write csr_wr_data with csr_wr_en only while idle.
`include "assert_macros.svh"

module length_prefixed_packet_deframer_unit #(
   parameter int CHUNK_LENGTH_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   lppd_req_if.sink                       req_ch,
   lppd_rsp_if.source                     rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [lppd_pkg::MSG_LEN_W-1:0] csr_wr_data
);
   import lppd_pkg::*;

   logic [MSG_LEN_W-1:0] max_size_ff, max_size_in;
   item_type             in_item, s1_item;
   pipe_ctl_type         ctl;
   logic                 advance;
   logic                 res_valid;
   result_type           res, out_res;

   assign max_size_in = csr_wr_en ? csr_wr_data : max_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= MAX_SIZE_RESET;
      end else begin
         max_size_ff <= max_size_in;
      end
   end

   assign in_item.data_byte = req_ch.data_byte;
   assign in_item.resync    = req_ch.resync;

   lppd_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_item  (in_item),
      .in_ready (req_ch.ready),
      .advance  (advance),
      .ctl      (ctl),
      .item     (s1_item)
   );

   lppd_parser #(
      .CHUNK_LENGTH_BITS (CHUNK_LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .max_size  (max_size_ff),
      .ctl       (ctl),
      .item      (s1_item),
      .res_valid (res_valid),
      .res       (res)
   );

   lppd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .advance   (advance),
      .out_valid (rsp_ch.valid),
      .out_res   (out_res),
      .out_ready (rsp_ch.ready)
   );

   assign rsp_ch.payload_byte   = out_res.payload_byte;
   assign rsp_ch.byte_valid     = out_res.byte_valid;
   assign rsp_ch.end_of_message = out_res.end_of_message;
   assign rsp_ch.message_length = out_res.message_length;
   assign rsp_ch.status         = out_res.status;

   `LPPD_ASSERT_NOW(a_byte_ok, rsp_ch.valid && rsp_ch.byte_valid, rsp_ch.status == ST_OK, "payload byte with error status")
   `LPPD_ASSERT_NOW(a_err_ends, rsp_ch.valid && rsp_ch.status != ST_OK, rsp_ch.end_of_message && !rsp_ch.byte_valid, "error result not a bare end of message")
   `LPPD_ASSERT_NOW(a_len_eom, rsp_ch.valid && !rsp_ch.end_of_message, rsp_ch.message_length == '0, "length outside end of message")
   `LPPD_ASSERT_NOW(a_stall, rsp_ch.valid && !rsp_ch.ready && ctl.stage_full, !req_ch.ready, "transfer taken while both stages held")
   `LPPD_ASSERT_NEXT(a_csr, csr_wr_en, max_size_ff == $past(csr_wr_data), "size limit write lost")

endmodule
